@@ hw/rtl/rotbd_pkg.sv @@
`timescale 1ns / 1ps

package rotbd_pkg;

    typedef enum logic [1:0] {
        CMD_FETCH = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_IDLE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ROM_NONE = 2'd0,
        ROM_ORIG = 2'd1,
        ROM_OVER = 2'd2,
        ROM_AUX  = 2'd3
    } t_rom_sel;

    typedef enum logic [1:0] {
        OP_CONST  = 2'd0,
        OP_RAM_RD = 2'd1,
        OP_RAM_WR = 2'd2
    } t_op;

    localparam int unsigned RAM_IDX_W = 12;

    localparam logic [15:0] TRAP_EN_BASE = 16'h3FF8;
    localparam int unsigned TRAP_DIS_N   = 7;
    localparam logic [15:0] TRAP_DIS_BASE [TRAP_DIS_N] = '{
        16'h0038, 16'h03B0, 16'h1600, 16'h2120, 16'h3FF0, 16'h8000, 16'h97F0
    };

    localparam logic [15:0] RAM_BASE  = 16'h4000;
    localparam logic [15:0] AUX_END   = 16'hA000;
    localparam logic [15:0] IO_IN0    = 16'h5000;
    localparam logic [15:0] IO_IN1    = 16'h5040;
    localparam logic [15:0] IO_DIP    = 16'h5080;
    localparam logic [7:0]  BYTE_NONE = 8'hFF;
    localparam logic [7:0]  DIP_RESET = 8'hFF;

    typedef struct packed {
        t_op                    op;
        logic [RAM_IDX_W-1:0]   ram_idx;
        logic [7:0]             wdata;
        logic [7:0]             rdata;
        t_rom_sel               rom_sel;
        logic [14:0]            rom_addr;
        logic                   overlay;
        logic                   irq;
    } t_entry;

endpackage

@@ hw/rtl/rotbd_front.sv @@
`timescale 1ns / 1ps

module rotbd_front
    import rotbd_pkg::*;
#(
    parameter int unsigned RAM_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [5:0]  i_buttons,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_q_full,
    output logic        o_push,
    output t_entry      o_entry
);

    logic       r_overlay;
    logic       n_overlay;
    logic       r_irq;
    logic       n_irq;
    logic [7:0] r_dip;
    logic       en_trap;
    logic       dis_trap;
    logic       ram_ok;
    logic [15:0] a;
    logic [15:0] wr_addr;
    t_cmd       cmd;
    t_entry     e;

    assign a           = i_address;
    assign cmd         = t_cmd'(i_cmd);
    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign o_push      = i_valid && o_ready;
    assign o_entry     = e;

    // A15 dropped at 0xC000 and above
    assign wr_addr = {a[15] & ~a[14], a[14:0]};
    assign en_trap = (a[15:3] == TRAP_EN_BASE[15:3]);
    assign ram_ok  = (32'(a[RAM_IDX_W-1:0]) < RAM_DEPTH);

    always_comb begin
        dis_trap = 1'b0;
        for (int k = 0; k < TRAP_DIS_N; k++) begin
            if (a[15:3] == TRAP_DIS_BASE[k][15:3]) begin
                dis_trap = 1'b1;
            end
        end
    end

    always_comb begin
        n_overlay  = r_overlay;
        n_irq      = r_irq;
        e.op       = OP_CONST;
        e.ram_idx  = a[RAM_IDX_W-1:0];
        e.wdata    = i_write_data;
        e.rdata    = BYTE_NONE;
        e.rom_sel  = ROM_NONE;
        e.rom_addr = 15'd0;
        unique case (cmd)
            CMD_FETCH, CMD_READ: begin
                if (en_trap) begin
                    n_overlay  = 1'b1;
                    e.rom_sel  = ROM_OVER;
                    e.rom_addr = a[14:0];
                end else if (dis_trap) begin
                    n_overlay  = 1'b0;
                    e.rom_sel  = ROM_ORIG;
                    e.rom_addr = {1'b0, a[13:0]};
                end else if (a[15:14] == 2'b00) begin
                    e.rom_sel  = r_overlay ? ROM_OVER : ROM_ORIG;
                    e.rom_addr = a[14:0];
                end else if (a[15]) begin
                    if (r_overlay) begin
                        e.rom_sel  = (a < AUX_END) ? ROM_AUX : ROM_OVER;
                        e.rom_addr = a[14:0];
                    end else begin
                        e.rom_sel  = ROM_ORIG;
                        e.rom_addr = {1'b0, a[13:0]};
                    end
                end else if (cmd == CMD_READ) begin
                    if (a[15:12] == RAM_BASE[15:12]) begin
                        if (ram_ok) begin
                            e.op = OP_RAM_RD;
                        end
                    end else if (a == IO_DIP) begin
                        e.rdata = r_dip;
                    end else if (a == IO_IN0) begin
                        e.rdata = {2'b11, ~i_buttons[4], 1'b1, ~i_buttons[3:0]};
                    end else if (a == IO_IN1) begin
                        e.rdata = {2'b11, ~i_buttons[5], 5'h1F};
                    end
                end
            end
            CMD_WRITE: begin
                if (en_trap) begin
                    n_overlay = 1'b1;
                end else if (dis_trap) begin
                    n_overlay = 1'b0;
                end else if (wr_addr[15:12] == RAM_BASE[15:12]) begin
                    if (ram_ok) begin
                        e.op = OP_RAM_WR;
                    end
                end else if (wr_addr == IO_IN0) begin
                    n_irq = i_write_data[0];
                end
                // sound and object registers have no readback
            end
            CMD_IDLE: begin
            end
            default: begin
            end
        endcase
        e.overlay = n_overlay;
        e.irq     = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlay <= 1'b0;
            r_irq     <= 1'b0;
            r_dip     <= DIP_RESET;
        end else begin
            if (o_push) begin
                r_overlay <= n_overlay;
                r_irq     <= n_irq;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_dip <= i_cfg_data;
            end
        end
    end

endmodule

@@ hw/rtl/rotbd_fifo.sv @@
`timescale 1ns / 1ps

module rotbd_fifo
    import rotbd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_entry o_entry
);

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    t_entry          r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_entry;
        end
    end

endmodule

@@ hw/rtl/rotbd_back.sv @@
`timescale 1ns / 1ps

module rotbd_back
    import rotbd_pkg::*;
#(
    parameter int unsigned RAM_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_entry      i_q_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_rom_select,
    output logic [14:0] o_rom_address,
    output logic        o_overlay_active,
    output logic        o_interrupt_enable
);

    localparam int unsigned AW = $clog2(RAM_DEPTH);

    logic [7:0]    r_ram [RAM_DEPTH];
    logic [7:0]    r_ram_q;
    logic          r_out_valid;
    t_entry        r_out;
    logic [AW-1:0] idx;

    assign idx   = i_q_entry.ram_idx[AW-1:0];
    assign o_pop = i_q_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_q_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_entry.op == OP_RAM_WR) begin
            r_ram[idx] <= i_q_entry.wdata;
        end
        if (o_pop) begin
            r_ram_q <= r_ram[idx];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_read_data        = (r_out.op == OP_RAM_RD) ? r_ram_q : r_out.rdata;
    assign o_rom_select       = r_out.rom_sel;
    assign o_rom_address      = r_out.rom_addr;
    assign o_overlay_active   = r_out.overlay;
    assign o_interrupt_enable = r_out.irq;

endmodule

@@ hw/rtl/rom_overlay_trap_bus_decoder.sv @@
// Path: the front classifies an accepted access beat and updates the flags, the queue
// stores it and the back output register holds its result while i_ready is low.
// Throughput: one access per cycle while o_ready is high (queue not full); a two-entry
// queue feeds the back, which does the single work RAM port access.
// Reset (synchronous, active low): overlay and IRQ enable cleared, DIP byte 0xFF,
// queue and output emptied. Work RAM contents are not cleared.
`timescale 1ns / 1ps

module rom_overlay_trap_bus_decoder
    import rotbd_pkg::*;
#(
    parameter int unsigned RAM_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [5:0]  i_buttons,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_rom_select,
    output logic [14:0] o_rom_address,
    output logic        o_overlay_active,
    output logic        o_interrupt_enable,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic   q_full;
    logic   q_valid;
    logic   push;
    logic   pop;
    t_entry push_entry;
    t_entry head_entry;

    rotbd_front #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_buttons    (i_buttons),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    rotbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_entry (head_entry)
    );

    rotbd_back #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_entry          (head_entry),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_read_data        (o_read_data),
        .o_rom_select       (o_rom_select),
        .o_rom_address      (o_rom_address),
        .o_overlay_active   (o_overlay_active),
        .o_interrupt_enable (o_interrupt_enable)
    );

endmodule

@@ hw/rtl/rotbd_chk.sv @@
`timescale 1ns / 1ps

module rotbd_chk
    import rotbd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_read_data,
    input logic [1:0]  o_rom_select,
    input logic [14:0] o_rom_address,
    input logic        o_overlay_active,
    input logic        o_interrupt_enable
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data)
            && $stable(o_rom_select) && $stable(o_rom_address)
            && $stable(o_overlay_active) && $stable(o_interrupt_enable))
        else $error("result beat changed while stalled");

    a_no_rom_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rom_select == ROM_NONE |-> o_rom_address == 15'd0)
        else $error("ROM offset set without a ROM bank");

    a_aux_overlay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rom_select == ROM_AUX |-> o_overlay_active)
        else $error("auxiliary ROM selected with overlay off");

    a_rom_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rom_select != ROM_NONE |-> o_read_data == BYTE_NONE)
        else $error("ROM access returned bus data");

endmodule

bind rom_overlay_trap_bus_decoder rotbd_chk u_rotbd_chk (.*);

@@ test/rotbd_bus_check.sv @@
`timescale 1ns / 1ps

module rotbd_bus_check
    import rotbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc_valid,
    input  logic        i_acc_ready,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [5:0]  i_buttons,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [7:0]  i_read_data,
    input  logic [1:0]  i_rom_select,
    input  logic [14:0] i_rom_address,
    input  logic        i_overlay_active,
    input  logic        i_interrupt_enable,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [15:0] ROM_HI_BASE = 16'h8000;
    localparam logic [15:0] MIRROR_BASE = 16'hC000;
    localparam logic [15:0] OBJ_BASE    = 16'h5060;
    localparam logic [15:0] WIN_LAST    = 16'd7;
    localparam logic [7:0]  NIBBLE_MASK = 8'h0F;

    typedef struct packed {
        logic [7:0]  rdata;
        t_rom_sel    sel;
        logic [14:0] rom_off;
        logic        overlay;
        logic        irq;
    } t_bus_result;

    logic [7:0]  dip_copy;
    logic        overlay_copy;
    logic        irq_copy;
    logic [7:0]  ram_copy [2**RAM_IDX_W];
    logic [7:0]  obj_copy [16];
    logic [3:0]  sound_copy [32];
    t_bus_result expected_q [$];
    int          fail_count = 0;

    function automatic logic in_window(logic [15:0] a, logic [15:0] base);
        return (a >= base) && (a - base <= WIN_LAST);
    endfunction

    function automatic logic in_disable_trap(logic [15:0] a);
        logic hit = 1'b0;
        for (int k = 0; k < TRAP_DIS_N; k++) begin
            hit |= in_window(a, TRAP_DIS_BASE[k]);
        end
        return hit;
    endfunction

    function automatic logic [7:0] io_byte(logic [15:0] a, logic [5:0] b);
        if (a[15:12] == RAM_BASE[15:12]) return ram_copy[a[11:0]];
        if (a == IO_DIP) return dip_copy;
        if (a == IO_IN0) return ~{2'b00, b[4], 1'b0, b[3:0]};
        if (a == IO_IN1) return ~{2'b00, b[5], 5'b00000};
        return BYTE_NONE;
    endfunction

    // Decodes one access beat and advances the shadow state.
    function automatic t_bus_result predict_access(t_cmd c, logic [15:0] a,
                                                   logic [7:0] d, logic [5:0] b);
        t_bus_result r;
        logic [15:0] wa;
        r.rdata   = BYTE_NONE;
        r.sel     = ROM_NONE;
        r.rom_off = '0;
        if (c == CMD_FETCH || c == CMD_READ) begin
            if (in_window(a, TRAP_EN_BASE)) begin
                overlay_copy = 1'b1;
                r.sel        = ROM_OVER;
                r.rom_off    = a[14:0];
            end else if (in_disable_trap(a)) begin
                overlay_copy = 1'b0;
                r.sel        = ROM_ORIG;
                r.rom_off    = {1'b0, a[13:0]};
            end else if (a < RAM_BASE) begin
                r.sel     = overlay_copy ? ROM_OVER : ROM_ORIG;
                r.rom_off = a[14:0];
            end else if (a >= ROM_HI_BASE) begin
                if (overlay_copy) begin
                    r.sel     = (a < AUX_END) ? ROM_AUX : ROM_OVER;
                    r.rom_off = a[14:0];
                end else begin
                    r.sel     = ROM_ORIG;
                    r.rom_off = {1'b0, a[13:0]};
                end
            end else if (c == CMD_READ) begin
                r.rdata = io_byte(a, b);
            end
        end else if (c == CMD_WRITE) begin
            if (in_window(a, TRAP_EN_BASE)) begin
                overlay_copy = 1'b1;
            end else if (in_disable_trap(a)) begin
                overlay_copy = 1'b0;
            end else begin
                wa = a;
                if (a >= MIRROR_BASE) wa[15] = 1'b0;
                if (wa[15:12] == RAM_BASE[15:12]) begin
                    ram_copy[wa[11:0]] = d;
                end else if (wa[15:8] == IO_IN0[15:8]) begin
                    if (wa[15:4] == OBJ_BASE[15:4]) obj_copy[wa[3:0]] = d;
                    if (wa == IO_IN0) irq_copy = d[0];
                    if (wa[15:5] == IO_IN1[15:5]) sound_copy[wa[4:0]] = 4'(d & NIBBLE_MASK);
                end
            end
        end
        r.overlay = overlay_copy;
        r.irq     = irq_copy;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            fail_count++;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_bus_result want;
        if (!i_rst_n) begin
            dip_copy     = DIP_RESET;
            overlay_copy = 1'b0;
            irq_copy     = 1'b0;
            foreach (sound_copy[i]) sound_copy[i] = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) dip_copy = i_cfg_data;
            // results always leave in a later cycle than their access, so pop first
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $error("result beat with no access outstanding");
                end else begin
                    want = expected_q.pop_front();
                    check_field("read_data", want.rdata, i_read_data);
                    check_field("rom_select", want.sel, i_rom_select);
                    check_field("rom_address", want.rom_off, i_rom_address);
                    check_field("overlay_active", want.overlay, i_overlay_active);
                    check_field("interrupt_enable", want.irq, i_interrupt_enable);
                end
            end
            if (i_acc_valid && i_acc_ready) begin
                expected_q.push_back(predict_access(t_cmd'(i_cmd), i_address,
                                                    i_write_data, i_buttons));
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import rotbd_pkg::*;

    localparam int          CYCLE_LIMIT  = 100000;
    localparam int          PHASE_ITEMS  = 225;
    localparam int          PHASES       = 6;
    localparam logic [15:0] ROM_HI_BASE  = 16'h8000;
    localparam logic [15:0] MIRROR_BASE  = 16'hC000;
    localparam logic [15:0] IO_TOP       = 16'h7FFF;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        acc_valid  = 1'b0;
    logic        acc_ready;
    logic [1:0]  cmd        = CMD_IDLE;
    logic [15:0] address    = '0;
    logic [7:0]  write_data = '0;
    logic [5:0]  buttons    = '0;
    logic        res_valid;
    logic        res_ready  = 1'b0;
    logic [7:0]  read_data;
    logic [1:0]  rom_select;
    logic [14:0] rom_address;
    logic        overlay_active;
    logic        interrupt_enable;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data   = '0;
    logic        quiet      = 1'b0;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          ram_written [2**RAM_IDX_W];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rom_overlay_trap_bus_decoder dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (acc_valid),
        .o_ready            (acc_ready),
        .i_cmd              (cmd),
        .i_address          (address),
        .i_write_data       (write_data),
        .i_buttons          (buttons),
        .o_valid            (res_valid),
        .i_ready            (res_ready),
        .o_read_data        (read_data),
        .o_rom_select       (rom_select),
        .o_rom_address      (rom_address),
        .o_overlay_active   (overlay_active),
        .o_interrupt_enable (interrupt_enable),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_data         (cfg_data)
    );

    rotbd_bus_check u_bus_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_acc_valid        (acc_valid),
        .i_acc_ready        (acc_ready),
        .i_cmd              (cmd),
        .i_address          (address),
        .i_write_data       (write_data),
        .i_buttons          (buttons),
        .i_res_valid        (res_valid),
        .i_res_ready        (res_ready),
        .i_read_data        (read_data),
        .i_rom_select       (rom_select),
        .i_rom_address      (rom_address),
        .i_overlay_active   (overlay_active),
        .i_interrupt_enable (interrupt_enable),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_data         (cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always @(posedge clk) begin
        res_ready <= quiet || ($urandom_range(0, 99) >= 33);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_access(input t_cmd c, input logic [15:0] a,
                               input logic [7:0] d, input logic [5:0] b);
        while (!quiet && $urandom_range(0, 99) < 33) begin
            acc_valid <= 1'b0;
            @(posedge clk);
        end
        if (c == CMD_WRITE && (a[15:12] == RAM_BASE[15:12] || a[15:12] == MIRROR_BASE[15:12]))
            ram_written[a[11:0]] = 1'b1;
        acc_valid  <= 1'b1;
        cmd        <= c;
        address    <= a;
        write_data <= d;
        buttons    <= b;
        @(posedge clk);
        while (!acc_ready) @(posedge clk);
    endtask

    task automatic send_random();
        t_cmd        c;
        logic [15:0] a;
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            k = $urandom_range(0, TRAP_DIS_N);
            a = ((k == TRAP_DIS_N) ? TRAP_EN_BASE : TRAP_DIS_BASE[k]) + 16'($urandom_range(0, 7));
        end else if (pick < 35) begin
            a = 16'($urandom_range(0, RAM_BASE - 1));
        end else if (pick < 50) begin
            a = 16'($urandom_range(ROM_HI_BASE, 16'hFFFF));
        end else if (pick < 65) begin
            a = RAM_BASE + 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                          : $urandom_range(0, 31));
        end else if (pick < 72) begin
            a = MIRROR_BASE + 16'($urandom_range(0, 31));
        end else if (pick < 85) begin
            case ($urandom_range(0, 3))
                0: a = IO_IN0;
                1: a = IO_IN1;
                2: a = IO_DIP;
                default: a = IO_IN1 + 16'($urandom_range(0, 16'h2F));
            endcase
        end else begin
            a = 16'($urandom_range(RAM_BASE, IO_TOP));
        end
        k = $urandom_range(0, 19);
        if (k == 0)      c = CMD_IDLE;
        else if (k < 7)  c = CMD_FETCH;
        else if (k < 14) c = CMD_READ;
        else             c = CMD_WRITE;
        // never read a RAM byte that has not been stored yet
        if (c == CMD_READ && a[15:12] == RAM_BASE[15:12] && !ram_written[a[11:0]])
            c = CMD_WRITE;
        send_access(c, a, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
    endtask

    task automatic wait_drained();
        acc_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_dip(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] dip_set [PHASES];
        dip_set = '{8'h00, 8'hFF, 8'h5A, 8'($urandom_range(0, 255)), 8'hA5,
                    8'($urandom_range(0, 255))};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_access(CMD_FETCH, 16'h0000, 8'h00, 6'h00);
        send_access(CMD_READ,  16'h3FFF, 8'h00, 6'h00);
        send_access(CMD_FETCH, 16'h1234, 8'h00, 6'h00);
        send_access(CMD_FETCH, 16'h9FFF, 8'h00, 6'h00);
        send_access(CMD_READ,  16'hFFFF, 8'h00, 6'h00);
        send_access(CMD_WRITE, 16'h4000, 8'hA5, 6'h00);
        send_access(CMD_WRITE, 16'h4FFF, 8'h00, 6'h3F);
        send_access(CMD_WRITE, 16'hCFFE, 8'hFF, 6'h00);
        send_access(CMD_FETCH, 16'h4000, 8'h00, 6'h00);
        send_access(CMD_READ,  16'h4000, 8'h00, 6'h00);
        send_access(CMD_READ,  16'h4FFF, 8'h00, 6'h00);
        send_access(CMD_READ,  16'h4FFE, 8'h00, 6'h00);
        send_access(CMD_READ,  16'h0038, 8'h00, 6'h00);
        send_access(CMD_READ,  16'hA000, 8'h00, 6'h00);
        send_access(CMD_WRITE, 16'h3FF8, 8'h77, 6'h00);
        send_access(CMD_WRITE, 16'h97F7, 8'h77, 6'h00);
        send_access(CMD_READ,  IO_IN0,   8'h00, 6'h3F);
        send_access(CMD_READ,  IO_IN0,   8'h00, 6'h00);
        send_access(CMD_READ,  IO_IN1,   8'h00, 6'h20);
        send_access(CMD_READ,  IO_IN1,   8'h00, 6'h1F);
        send_access(CMD_READ,  IO_DIP,   8'h00, 6'h00);
        send_access(CMD_WRITE, IO_IN0,   8'h01, 6'h00);
        send_access(CMD_WRITE, 16'hD000, 8'hFE, 6'h00);
        send_access(CMD_WRITE, 16'h506F, 8'h12, 6'h00);
        send_access(CMD_IDLE,  16'h3FF8, 8'hFF, 6'h3F);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_dip(dip_set[p]);
            quiet <= (p == 2);
            repeat (PHASE_ITEMS) send_random();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
